// ===== rtl/ecg_pkg.sv =====
// Shared types and constants for the ElGamal cipher engine.
// Used by every module in the rtl folder; depends on nothing else.
package ecg_pkg;

  // Widths of the external fields.
  localparam int FIELD_W = 32;
  localparam int ACT_W   = 2;
  localparam int CIDX_W  = 2;

  // Action codes carried in the input request.
  localparam logic [ACT_W-1:0] ACT_KEYGEN  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ENCRYPT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DECRYPT = 2'd2;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_MODULUS   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_GENERATOR = 2'd1;
  localparam logic [CIDX_W-1:0] REG_PRIVKEY   = 2'd2;

  // Control broadcast from the multiplier sequencer to every bit cell.
  typedef struct packed {
    logic load;     // load operands, clear accumulator
    logic step;     // perform one add-and-double step
    logic take_acc; // current multiplier bit is one
    logic ge_acc;   // accumulator sum is not below the modulus
    logic ge_a;     // doubled multiplicand is not below the modulus
  } ecg_ctl_t;

endpackage

// ===== rtl/ecg_cell.sv =====
// One bit slice of the add-and-double modular multiplier.
// Holds one bit each of accumulator, multiplicand and multiplier; uses ecg_pkg.
module ecg_cell (
  input  logic             clk,
  input  ecg_pkg::ecg_ctl_t ctl,
  input  logic             m_bit,
  input  logic             a_init,
  input  logic             b_init,
  input  logic             b_left,
  input  logic             c_acc_in,
  input  logic             bw_acc_in,
  input  logic             c_a_in,
  input  logic             bw_a_in,
  output logic             acc_bit,
  output logic             a_bit,
  output logic             b_bit,
  output logic             c_acc_out,
  output logic             bw_acc_out,
  output logic             c_a_out,
  output logic             bw_a_out
);
  import ecg_pkg::*;

  logic s_acc, d_acc, s_a, d_a;

  // Accumulator plus multiplicand, then the trial subtraction of the modulus.
  assign s_acc      = acc_bit ^ a_bit ^ c_acc_in;
  assign c_acc_out  = (acc_bit & a_bit) | (c_acc_in & (acc_bit ^ a_bit));
  assign d_acc      = s_acc ^ m_bit ^ bw_acc_in;
  assign bw_acc_out = (~s_acc & m_bit) | (~(s_acc ^ m_bit) & bw_acc_in);

  // Multiplicand doubled, then the trial subtraction of the modulus.
  assign s_a      = c_a_in;
  assign c_a_out  = a_bit;
  assign d_a      = s_a ^ m_bit ^ bw_a_in;
  assign bw_a_out = (~s_a & m_bit) | (~(s_a ^ m_bit) & bw_a_in);

  // The multiplier bit moves one cell towards bit zero on every step.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      acc_bit <= 1'b0;
      a_bit   <= a_init;
      b_bit   <= b_init;
    end else if (ctl.step) begin
      if (ctl.take_acc) begin
        acc_bit <= ctl.ge_acc ? d_acc : s_acc;
      end
      a_bit <= ctl.ge_a ? d_a : s_a;
      b_bit <= b_left;
    end
  end

endmodule

// ===== rtl/ecg_mulmod.sv =====
// Bit-serial modular multiplier built from a row of ecg_cell slices.
// Returns a * b mod m for a below m and any b; uses ecg_pkg and ecg_cell.
module ecg_mulmod #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] a_in,
  input  logic [WIDTH-1:0] b_in,
  input  logic [WIDTH-1:0] m,
  output logic             done,
  output logic [WIDTH-1:0] result
);
  import ecg_pkg::*;

  localparam int CNT_W = $clog2(WIDTH);

  ecg_ctl_t         ctl;
  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [WIDTH-1:0] a_vec, b_vec;
  logic [WIDTH:0]   b_ext, c_acc, bw_acc, c_a, bw_a;

  assign b_ext     = {1'b0, b_vec};
  assign c_acc[0]  = 1'b0;
  assign bw_acc[0] = 1'b0;
  assign c_a[0]    = 1'b0;
  assign bw_a[0]   = 1'b0;

  // Decisions taken at the top of the chain are broadcast back to all cells.
  assign ctl.load     = start;
  assign ctl.step     = running;
  assign ctl.take_acc = b_vec[0];
  assign ctl.ge_acc   = c_acc[WIDTH] | ~bw_acc[WIDTH];
  assign ctl.ge_a     = c_a[WIDTH] | ~bw_a[WIDTH];

  // The row of bit cells.
  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    ecg_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .m_bit      (m[i]),
      .a_init     (a_in[i]),
      .b_init     (b_in[i]),
      .b_left     (b_ext[i+1]),
      .c_acc_in   (c_acc[i]),
      .bw_acc_in  (bw_acc[i]),
      .c_a_in     (c_a[i]),
      .bw_a_in    (bw_a[i]),
      .acc_bit    (result[i]),
      .a_bit      (a_vec[i]),
      .b_bit      (b_vec[i]),
      .c_acc_out  (c_acc[i+1]),
      .bw_acc_out (bw_acc[i+1]),
      .c_a_out    (c_a[i+1]),
      .bw_a_out   (bw_a[i+1])
    );
  end

  // Step counter: one step per multiplier bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        if (cnt == CNT_W'(WIDTH - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/ecg_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the Euclid steps.
// Depends on ecg_pkg only for the house import.
module ecg_divider #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] num,
  input  logic [WIDTH-1:0] den,
  output logic             done,
  output logic [WIDTH-1:0] quot,
  output logic [WIDTH-1:0] rem
);
  import ecg_pkg::*;

  localparam int CNT_W = $clog2(WIDTH);

  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [WIDTH-1:0] nsh, dvs;
  logic [WIDTH:0]   trial, diff;
  logic             ge;

  // Bring down the next numerator bit and try the subtraction.
  assign trial = {rem, nsh[WIDTH-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = ~diff[WIDTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        if (cnt == CNT_W'(WIDTH - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      nsh  <= num;
      dvs  <= den;
      rem  <= '0;
      quot <= '0;
    end else if (running) begin
      nsh  <= {nsh[WIDTH-2:0], 1'b0};
      quot <= {quot[WIDTH-2:0], ge};
      rem  <= ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
    end
  end

endmodule

// ===== rtl/elgamal_cipher_engine_top.sv =====
// ElGamal cipher engine over a configurable modulus. Each request takes one
// action code and gives exactly one result. Products and divisions run on a single
// bit-serial modular multiplier (a row of WIDTH bit cells) and a
// one-bit-per-cycle divider, driven by a sequencer that handles one request
// at a time. A modular power scans all WIDTH exponent bits with up to two
// products per bit. Key generation costs a reduction and one power,
// encryption three powers plus two reductions and a product, decryption a
// reduction, one power, up to about 1.5*WIDTH Euclid steps and a product. A
// modulus below two or an unused action code is answered without any arithmetic.
// Depends on ecg_pkg, ecg_mulmod, ecg_cell and ecg_divider.
module elgamal_cipher_engine_top #(
  parameter int WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  // Input requests.
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // tdata: message, random_exponent, cipher_first, cipher_second.
  input  logic [4*ecg_pkg::FIELD_W-1:0] s_axis_tdata,
  // tuser: action.
  input  logic [ecg_pkg::ACT_W-1:0]   s_axis_tuser,
  // Results.
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // tdata: result_first, result_second.
  output logic [2*ecg_pkg::FIELD_W-1:0] m_axis_tdata,
  // tuser: status.
  output logic                        m_axis_tuser,
  // Configuration writes.
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ecg_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [ecg_pkg::FIELD_W-1:0] cfg_data
);
  import ecg_pkg::*;

  localparam int CNT_W = $clog2(WIDTH);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_TASK = 10'b0000000010,
    S_RED  = 10'b0000000100,
    S_PMUL = 10'b0000001000,
    S_PSQ  = 10'b0000010000,
    S_EUC  = 10'b0000100000,
    S_DIV  = 10'b0001000000,
    S_TMUL = 10'b0010000000,
    S_FMUL = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  state_t             state;
  logic [FIELD_W-1:0] modulus, generator, privkey;
  logic [ACT_W-1:0]   act;
  logic [WIDTH-1:0]   msg, rexp, c1, c2;
  logic [WIDTH-1:0]   p_w, g_w, d_w;
  logic [WIDTH-1:0]   base, acc, ex, pub, first, second;
  logic [WIDTH-1:0]   r1, r2, t1, t2, tdiff;
  logic               status;
  logic [1:0]         phase;
  logic [CNT_W-1:0]   cnt;
  logic               pend, mstart, dstart;
  logic [WIDTH-1:0]   mop_a, mop_b;
  logic               mdone, ddone;
  logic [WIDTH-1:0]   mres, dquot, drem;
  logic [FIELD_W-1:0] out_first, out_second;
  logic               out_status, out_valid;

  assign p_w = WIDTH'(modulus);
  assign g_w = WIDTH'(generator);
  assign d_w = WIDTH'(privkey);

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_second, out_first};
  assign m_axis_tuser  = out_status;

  // Difference used by the modular subtraction in the Euclid update.
  assign tdiff = t1 - mres;

  ecg_mulmod #(.WIDTH(WIDTH)) u_mulmod (
    .clk    (clk),
    .rst    (rst),
    .start  (mstart),
    .a_in   (mop_a),
    .b_in   (mop_b),
    .m      (p_w),
    .done   (mdone),
    .result (mres)
  );

  ecg_divider #(.WIDTH(WIDTH)) u_divider (
    .clk   (clk),
    .rst   (rst),
    .start (dstart),
    .num   (r1),
    .den   (r2),
    .done  (ddone),
    .quot  (dquot),
    .rem   (drem)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus   <= FIELD_W'(29);
      generator <= FIELD_W'(2);
      privkey   <= FIELD_W'(12);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODULUS:   modulus   <= cfg_data;
        REG_GENERATOR: generator <= cfg_data;
        REG_PRIVKEY:   privkey   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pend      <= 1'b0;
      mstart    <= 1'b0;
      dstart    <= 1'b0;
      out_valid <= 1'b0;
      phase     <= '0;
      cnt       <= '0;
    end else begin
      mstart <= 1'b0;
      dstart <= 1'b0;
      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            act    <= s_axis_tuser;
            msg    <= WIDTH'(s_axis_tdata[FIELD_W-1:0]);
            rexp   <= WIDTH'(s_axis_tdata[2*FIELD_W-1:FIELD_W]);
            c1     <= WIDTH'(s_axis_tdata[3*FIELD_W-1:2*FIELD_W]);
            c2     <= WIDTH'(s_axis_tdata[4*FIELD_W-1:3*FIELD_W]);
            first  <= '0;
            second <= '0;
            status <= 1'b0;
            phase  <= '0;
            if (p_w < WIDTH'(2) || !(s_axis_tuser == ACT_KEYGEN ||
                s_axis_tuser == ACT_ENCRYPT || s_axis_tuser == ACT_DECRYPT)) begin
              state <= S_OUT;
            end else begin
              state <= S_TASK;
            end
          end
        end
        // Pick the next piece of work for the current action.
        S_TASK: begin
          if (act == ACT_KEYGEN || (act == ACT_ENCRYPT && phase == 2'd0)) begin
            mstart <= 1'b1; pend <= 1'b1;
            mop_a  <= WIDTH'(1); mop_b <= g_w; ex <= d_w;
            state  <= S_RED;
          end else if (act == ACT_ENCRYPT && phase == 2'd1) begin
            mstart <= 1'b1; pend <= 1'b1;
            mop_a  <= WIDTH'(1); mop_b <= g_w; ex <= rexp;
            state  <= S_RED;
          end else if (act == ACT_ENCRYPT && phase == 2'd2) begin
            base  <= pub; ex <= rexp; acc <= WIDTH'(1); cnt <= '0;
            state <= S_PMUL;
          end else if (act == ACT_ENCRYPT) begin
            mstart <= 1'b1; pend <= 1'b1;
            mop_a  <= acc; mop_b <= msg;
            state  <= S_FMUL;
          end else if (phase == 2'd0) begin
            mstart <= 1'b1; pend <= 1'b1;
            mop_a  <= WIDTH'(1); mop_b <= c1; ex <= d_w;
            state  <= S_RED;
          end else if (phase == 2'd1) begin
            r1    <= p_w; r2 <= acc; t1 <= '0; t2 <= WIDTH'(1);
            state <= S_EUC;
          end else begin
            mstart <= 1'b1; pend <= 1'b1;
            mop_a  <= t1; mop_b <= c2;
            state  <= S_FMUL;
          end
        end
        // Reduction of the power base, then start the exponent scan.
        S_RED: begin
          if (mdone) begin
            pend  <= 1'b0;
            base  <= mres;
            acc   <= WIDTH'(1);
            cnt   <= '0;
            state <= S_PMUL;
          end
        end
        // Multiply the running power by the base when the exponent bit is set.
        S_PMUL: begin
          if (!pend) begin
            if (ex[0]) begin
              mstart <= 1'b1; pend <= 1'b1;
              mop_a  <= acc; mop_b <= base;
            end else begin
              state <= S_PSQ;
            end
          end else if (mdone) begin
            pend  <= 1'b0;
            acc   <= mres;
            state <= S_PSQ;
          end
        end
        // Square the base and move to the next exponent bit.
        S_PSQ: begin
          if (!pend) begin
            mstart <= 1'b1; pend <= 1'b1;
            mop_a  <= base; mop_b <= base;
          end else if (mdone) begin
            pend <= 1'b0;
            base <= mres;
            ex   <= ex >> 1;
            cnt  <= cnt + 1'b1;
            if (cnt == CNT_W'(WIDTH - 1)) begin
              phase <= phase + 1'b1;
              if (act == ACT_KEYGEN) begin
                first <= acc;
                state <= S_OUT;
              end else begin
                if (act == ACT_ENCRYPT && phase == 2'd0) pub <= acc;
                if (act == ACT_ENCRYPT && phase == 2'd1) first <= acc;
                state <= S_TASK;
              end
            end else begin
              state <= S_PMUL;
            end
          end
        end
        // Euclid loop test: stop on a zero remainder.
        S_EUC: begin
          if (r2 == '0) begin
            if (r1 == WIDTH'(1)) begin
              phase <= 2'd2;
              state <= S_TASK;
            end else begin
              status <= 1'b1;
              state  <= S_OUT;
            end
          end else begin
            dstart <= 1'b1;
            pend   <= 1'b1;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          if (ddone) begin
            mstart <= 1'b1;
            mop_a  <= t2; mop_b <= dquot;
            state  <= S_TMUL;
          end
        end
        // New coefficient is t1 minus quotient times t2, modulo p.
        S_TMUL: begin
          if (mdone) begin
            pend  <= 1'b0;
            t2    <= (t1 >= mres) ? tdiff : tdiff + p_w;
            t1    <= t2;
            r1    <= r2;
            r2    <= drem;
            state <= S_EUC;
          end
        end
        S_FMUL: begin
          if (mdone) begin
            pend <= 1'b0;
            if (act == ACT_ENCRYPT) begin
              second <= mres;
            end else begin
              first <= mres;
            end
            state <= S_OUT;
          end
        end
        // Hand the result to the output register once it is free.
        S_OUT: begin
          if (!out_valid || m_axis_tready) begin
            out_valid  <= 1'b1;
            out_first  <= FIELD_W'(first);
            out_second <= FIELD_W'(second);
            out_status <= status;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A multiplier launch only happens while the sequencer waits for a product.
  a_mstart_state: assert property (@(posedge clk) disable iff (rst)
    mstart |-> (state == S_RED || state == S_PMUL || state == S_PSQ ||
                state == S_TMUL || state == S_FMUL))
    else $error("multiplier started outside a product state");

  // A divider launch only happens on entry to the division wait.
  a_dstart_state: assert property (@(posedge clk) disable iff (rst)
    dstart |-> state == S_DIV)
    else $error("divider started outside the division state");

  // An accepted request always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> state != S_IDLE)
    else $error("request accepted without starting work");

  // A failed inverse gives an all-zero result.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("non-zero result alongside failure status");

endmodule

// ===== verif/elgamal_result_checker.sv =====
// Result checker for the ElGamal cipher engine: watches the request, result and
// configuration channels, predicts each result and compares it field by field.
// Depends on ecg_pkg for the action codes and register indexes.
`timescale 1ns / 100ps

module elgamal_result_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  // tdata: message, random_exponent, cipher_first, cipher_second.
  input  logic [127:0] s_axis_tdata,
  // tuser: action.
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: result_first, result_second.
  input  logic [63:0]  m_axis_tdata,
  // tuser: status.
  input  logic         m_axis_tuser,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           fails,
  output int           pending
);
  import ecg_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [31:0] first;
    logic [31:0] second;
    logic        status;
  } cipher_result_t;

  // Shadow copies of the configuration registers.
  logic [31:0] modulus, gen, key;

  cipher_result_t expected_results[$];

  function automatic u64_t mod_mul(u64_t a, u64_t b, u64_t m);
    return ((a % m) * (b % m)) % m;
  endfunction

  // Square-and-multiply, stopping once no exponent bits remain set.
  function automatic u64_t mod_pow(u64_t base, u64_t e, u64_t m);
    u64_t acc;
    acc = 1 % m;
    base = base % m;
    while (e != 0) begin
      if (e[0]) acc = mod_mul(acc, base, m);
      base = mod_mul(base, base, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  // Extended Euclid; the inverse is unique once brought into 0..m-1.
  function automatic bit mod_inverse(u64_t k, u64_t m, output u64_t inv);
    longint r1, r2, t1, t2, q, tmp;
    r1 = longint'(m);
    r2 = longint'(k % m);
    t1 = 0;
    t2 = 1;
    inv = 0;
    while (r2 != 0) begin
      q = r1 / r2;
      tmp = r1 - q * r2;
      r1 = r2;
      r2 = tmp;
      tmp = t1 - q * t2;
      t1 = t2;
      t2 = tmp;
    end
    if (r1 != 1) return 1'b0;
    if (t1 < 0) t1 = t1 + longint'(m);
    inv = u64_t'(t1);
    return 1'b1;
  endfunction

  function automatic cipher_result_t elgamal_predict(logic [1:0] act, logic [127:0] data);
    cipher_result_t res;
    u64_t p, g, d, pub, shared, inv;
    u64_t msg, rexp, c1, c2;
    res = '0;
    p = u64_t'(modulus);
    g = u64_t'(gen);
    d = u64_t'(key);
    msg = u64_t'(data[31:0]);
    rexp = u64_t'(data[63:32]);
    c1 = u64_t'(data[95:64]);
    c2 = u64_t'(data[127:96]);
    if (p >= 2) begin
      case (act)
        ACT_KEYGEN: res.first = 32'(mod_pow(g, d, p));
        ACT_ENCRYPT: begin
          pub = mod_pow(g, d, p);
          res.first = 32'(mod_pow(g, rexp, p));
          res.second = 32'(mod_mul(msg, mod_pow(pub, rexp, p), p));
        end
        ACT_DECRYPT: begin
          shared = mod_pow(c1, d, p);
          if (mod_inverse(shared, p, inv)) res.first = 32'(mod_mul(c2, inv, p));
          else res.status = 1'b1;
        end
        default: res = '0;
      endcase
    end
    return res;
  endfunction

  // Track configuration, predict on each request, check on each result.
  always @(posedge clk) begin
    cipher_result_t want;
    int errs;
    errs = 0;
    if (rst) begin
      modulus <= 32'd29;
      gen <= 32'd2;
      key <= 32'd12;
      fails <= 0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODULUS:   modulus <= cfg_data;
          REG_GENERATOR: gen <= cfg_data;
          REG_PRIVKEY:   key <= cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(elgamal_predict(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: %h %b", m_axis_tdata, m_axis_tuser);
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (want.first !== m_axis_tdata[31:0]) begin
            $error("result_first expected %h actual %h", want.first, m_axis_tdata[31:0]);
            errs++;
          end
          if (want.second !== m_axis_tdata[63:32]) begin
            $error("result_second expected %h actual %h", want.second, m_axis_tdata[63:32]);
            errs++;
          end
          if (want.status !== m_axis_tuser) begin
            $error("status expected %b actual %b", want.status, m_axis_tuser);
            errs++;
          end
        end
      end
      fails <= fails + errs;
    end
    pending <= expected_results.size();
  end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the ElGamal cipher engine: clock, reset, requests,
// configuration writes, result back-pressure and the verdict.
// Depends on ecg_pkg, elgamal_cipher_engine_top and elgamal_result_checker.
`timescale 1ns / 100ps

module tb;
  import ecg_pkg::*;

  localparam int HOLD_CYCLES = 30000;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam logic [31:0] BIG_PRIME = 32'hFFFF_FFFB;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;
  int           fails;
  int           pending;
  bit           steady = 1'b0;
  bit           hold_go = 1'b0;
  int           quiet_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  elgamal_cipher_engine_top #(.WIDTH(32)) u_top (.*);

  elgamal_result_checker u_chk (.*);

  // Result side: random back-pressure, one long hold-off on request.
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= 35);
      end
    end
  end

  // Watchdog on cycles with no request, result or register write moving.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || rst)
      quiet_cycles <= 0;
    else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  task automatic send_request(logic [1:0] act, logic [31:0] msg, logic [31:0] rexp,
                              logic [31:0] c1, logic [31:0] c2);
    if (!steady && $urandom_range(99) < 35) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {c2, c1, rexp, msg};
    s_axis_tuser <= act;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Stop offering and let every outstanding result drain.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(logic [31:0] p, logic [31:0] g, logic [31:0] d);
    drain_results();
    write_reg(REG_MODULUS, p);
    write_reg(REG_GENERATOR, g);
    write_reg(REG_PRIVKEY, d);
  endtask

  // Random requests, mostly encrypt and decrypt, with a few keygen and unused codes.
  task automatic random_requests(int count, bit with_hold);
    int pick;
    logic [1:0] act;
    for (int i = 0; i < count; i++) begin
      steady = (i >= 50 && i < 75);
      if (with_hold && i == 20) hold_go = 1'b1;
      pick = $urandom_range(99);
      if (pick < 15) act = ACT_KEYGEN;
      else if (pick < 55) act = ACT_ENCRYPT;
      else if (pick < 95) act = ACT_DECRYPT;
      else act = 2'd3;
      send_request(act, $urandom, $urandom, $urandom, $urandom);
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings, extremes of every field and each action.
    send_request(ACT_KEYGEN, '0, '0, '0, '0);
    send_request(ACT_ENCRYPT, 32'd0, 32'd1, '0, '0);
    send_request(ACT_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0);
    send_request(ACT_ENCRYPT, 32'd5, 32'd0, '0, '0);
    send_request(ACT_DECRYPT, '0, '0, 32'd0, 32'd7);
    send_request(ACT_DECRYPT, '0, '0, 32'd58, 32'd3);
    send_request(ACT_DECRYPT, '0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Largest 32-bit prime with all-ones generator and key.
    set_config(BIG_PRIME, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(ACT_KEYGEN, '0, '0, '0, '0);
    send_request(ACT_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0);
    send_request(ACT_DECRYPT, '0, '0, 32'hFFFF_FFFF, 32'h8000_0001);
    send_request(ACT_DECRYPT, '0, '0, BIG_PRIME, 32'd1);

    // Composite modulus: shared values without an inverse; key zero.
    set_config(32'd15, 32'd1, 32'd0);
    send_request(ACT_KEYGEN, '0, '0, '0, '0);
    send_request(ACT_DECRYPT, '0, '0, 32'd6, 32'd4);
    send_request(ACT_ENCRYPT, 32'd14, 32'd3, '0, '0);
    drain_results();
    write_reg(REG_PRIVKEY, 32'd1);
    send_request(ACT_DECRYPT, '0, '0, 32'd6, 32'd4);
    send_request(ACT_DECRYPT, '0, '0, 32'd7, 32'd4);

    // Moduli below two, and two itself.
    set_config(32'd0, 32'd2, 32'd12);
    send_request(ACT_KEYGEN, '0, '0, '0, '0);
    send_request(ACT_DECRYPT, '0, '0, 32'd3, 32'd3);
    set_config(32'd1, 32'd2, 32'd12);
    send_request(ACT_ENCRYPT, 32'd9, 32'd9, '0, '0);
    set_config(32'd2, 32'd3, 32'd5);
    send_request(ACT_ENCRYPT, 32'd1, 32'd4, '0, '0);
    send_request(ACT_DECRYPT, '0, '0, 32'd1, 32'd1);

    // Random phases over several settings; the first holds off results once.
    set_config(BIG_PRIME, $urandom, $urandom);
    random_requests(83, 1'b1);
    set_config(32'd1000003, $urandom, $urandom);
    random_requests(83, 1'b0);
    set_config(32'd65521, $urandom, $urandom);
    random_requests(83, 1'b0);

    drain_results();
    repeat (20) @(posedge clk);
    if (fails == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ecg_pkg.sv
rtl/ecg_cell.sv
rtl/ecg_mulmod.sv
rtl/ecg_divider.sv
rtl/elgamal_cipher_engine_top.sv
verif/elgamal_result_checker.sv
verif/tb.sv
